// ===== rtl/core/jfc_pkg.sv =====
// jfc_pkg: shared types, widths, codes and name helpers of the print job queue.
// No dependencies; compile first.
`default_nettype none

package jfc_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int NAME_CHARS_DEF  = 8;
   localparam int NAME_W          = 64;
   localparam int PAGE_W          = 16;
   localparam int POS_W           = 7;
   localparam int NAME_BYTES      = 8;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_CANCEL = 2'd1,
      MODE_PRINT  = 2'd2,
      MODE_STATUS = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      OUT_ADDED     = 3'd0,
      OUT_CANCELLED = 3'd1,
      OUT_NOT_FOUND = 3'd2,
      OUT_PRINTED   = 3'd3,
      OUT_STATUS    = 3'd4,
      OUT_EMPTY     = 3'd5,
      OUT_FULL      = 3'd6
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMD,
      ST_WALK,
      ST_FIN
   } state_type;

   // Fold A-Z to a-z.
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   // Cut to chars bytes and clear everything after the first zero byte.
   function automatic logic [NAME_W-1:0] normalize_name(input logic [NAME_W-1:0] name,
                                                        input int chars);
      logic [NAME_W-1:0] r;
      logic              stop;
      r    = '0;
      stop = 1'b0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (i >= chars || name[8*i +: 8] == 8'h00) begin
            stop = 1'b1;
         end
         if (!stop) begin
            r[8*i +: 8] = name[8*i +: 8];
         end
      end
      return r;
   endfunction

   // Case-insensitive compare; ends with a match where both bytes are zero.
   function automatic logic names_match(input logic [NAME_W-1:0] a,
                                        input logic [NAME_W-1:0] b,
                                        input int chars);
      logic [7:0] ca;
      logic [7:0] cb;
      logic       done;
      logic       hit;
      done = 1'b0;
      hit  = 1'b1;
      for (int i = 0; i < NAME_BYTES; i++) begin
         ca = fold_case(a[8*i +: 8]);
         cb = fold_case(b[8*i +: 8]);
         if (!done && i < chars) begin
            if (ca != cb) begin
               hit  = 1'b0;
               done = 1'b1;
            end else if (ca == 8'h00) begin
               done = 1'b1;
            end
         end
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/jfc_if.sv =====
// jfc_req_if / jfc_rsp_if: valid/ready channels of the print job queue.
// Depends on jfc_pkg.
`default_nettype none

interface jfc_req_if;
   logic                      valid;
   logic                      ready;
   jfc_pkg::mode_type         mode;
   logic [jfc_pkg::NAME_W-1:0] job_name;
   logic [jfc_pkg::PAGE_W-1:0] page_total;

   modport source (output valid, mode, job_name, page_total, input ready);
   modport sink   (input valid, mode, job_name, page_total, output ready);
endinterface

interface jfc_rsp_if;
   logic                       valid;
   logic                       ready;
   jfc_pkg::outcome_type       outcome;
   logic [jfc_pkg::POS_W-1:0]  entry_position;
   logic [jfc_pkg::NAME_W-1:0] result_name;
   logic [jfc_pkg::PAGE_W-1:0] result_pages;
   logic                       last_result;

   modport source (output valid, outcome, entry_position, result_name, result_pages,
                   last_result, input ready);
   modport sink   (input valid, outcome, entry_position, result_name, result_pages,
                   last_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/job_fifo_with_cancel_top.sv =====
// Print job queue with cancel by name; depends on jfc_pkg and jfc_if.
// Add, and any command on an empty queue, answer from the command state; print reads
// the head entry and answers from the walk state; status lists one entry a cycle unless
// the output stalls. Cancel walks one entry a cycle through the one-read, one-write memory,
// then reports from the closing state. A new command is taken only in the idle state, once
// the last one has loaded its final result; output stalls hold every command.
// Reset: synchronous; empties the queue and the output register, memory contents stay.
`default_nettype none

module job_fifo_with_cancel_top #(
   parameter int QUEUE_DEPTH = jfc_pkg::QUEUE_DEPTH_DEF,
   parameter int NAME_CHARS  = jfc_pkg::NAME_CHARS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   jfc_req_if.sink     req_chan,
   jfc_rsp_if.source   rsp_chan
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int NAME_W  = jfc_pkg::NAME_W;
   localparam int PAGE_W  = jfc_pkg::PAGE_W;
   localparam int POS_W   = jfc_pkg::POS_W;
   localparam int ENTRY_W = NAME_W + PAGE_W;

   // Ring index: base + offset, folded back below QUEUE_DEPTH.
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + (PTR_W+1)'(off);
      if (sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   // Control state
   jfc_pkg::state_type state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;       // entry being walked, from the head
   logic [CNT_W-1:0]   kept_ff, kept_in;     // survivors of a cancel so far
   logic               found_ff, found_in;

   // Latched command
   jfc_pkg::mode_type  cmd_mode_ff, cmd_mode_in;
   logic [NAME_W-1:0]  cmd_name_ff, cmd_name_in;
   logic [PAGE_W-1:0]  cmd_pages_ff, cmd_pages_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   jfc_pkg::outcome_type rsp_outcome_ff, rsp_outcome_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [NAME_W-1:0]    rsp_name_ff, rsp_name_in;
   logic [PAGE_W-1:0]    rsp_pages_ff, rsp_pages_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Entry memory: {name, pages}, registered read port
   logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_en;
   logic [PTR_W-1:0]   rd_addr;
   logic               mem_we;
   logic [PTR_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   // Result to load into the output register
   logic                 emit;
   jfc_pkg::outcome_type emit_outcome;
   logic [POS_W-1:0]     emit_pos;
   logic [NAME_W-1:0]    emit_name;
   logic [PAGE_W-1:0]    emit_pages;
   logic                 emit_last;

   logic               req_fire;
   logic               out_free;
   logic [CNT_W-1:0]   idx_next;
   logic               walk_last;
   logic [NAME_W-1:0]  rd_name;
   logic [PAGE_W-1:0]  rd_pages;

   assign req_chan.ready          = (state_ff == jfc_pkg::ST_IDLE);
   assign req_fire                = req_chan.valid && req_chan.ready;
   // The output register can take a new item when empty or being drained now.
   assign out_free                = !rsp_valid_ff || rsp_chan.ready;
   assign idx_next                = idx_ff + CNT_W'(1);
   assign walk_last               = (idx_next == count_ff);
   assign rd_name                 = rd_data_ff[ENTRY_W-1 -: NAME_W];
   assign rd_pages                = rd_data_ff[PAGE_W-1:0];

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.outcome        = rsp_outcome_ff;
   assign rsp_chan.entry_position = rsp_pos_ff;
   assign rsp_chan.result_name    = rsp_name_ff;
   assign rsp_chan.result_pages   = rsp_pages_ff;
   assign rsp_chan.last_result    = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      kept_in      = kept_ff;
      found_in     = found_ff;
      cmd_mode_in  = cmd_mode_ff;
      cmd_name_in  = cmd_name_ff;
      cmd_pages_in = cmd_pages_ff;

      rd_en        = 1'b0;
      rd_addr      = ring_add(head_ff, idx_next);
      mem_we       = 1'b0;
      mem_waddr    = ring_add(head_ff, count_ff);
      mem_wdata    = {jfc_pkg::normalize_name(cmd_name_ff, NAME_CHARS), cmd_pages_ff};

      emit         = 1'b0;
      emit_outcome = jfc_pkg::OUT_ADDED;
      emit_pos     = '0;
      emit_name    = '0;
      emit_pages   = '0;
      emit_last    = 1'b1;

      case (state_ff)
         jfc_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd_mode_in  = req_chan.mode;
               cmd_name_in  = req_chan.job_name;
               cmd_pages_in = req_chan.page_total;
               state_in     = jfc_pkg::ST_CMD;
            end
         end

         jfc_pkg::ST_CMD: begin
            if (cmd_mode_ff == jfc_pkg::MODE_ADD) begin
               // Append at the tail, or report full.
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = jfc_pkg::ST_IDLE;
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     emit_outcome = jfc_pkg::OUT_FULL;
                  end else begin
                     emit_outcome = jfc_pkg::OUT_ADDED;
                     mem_we       = 1'b1;
                     count_in     = count_ff + CNT_W'(1);
                  end
               end
            end else if (count_ff == '0) begin
               if (out_free) begin
                  emit         = 1'b1;
                  emit_outcome = jfc_pkg::OUT_EMPTY;
                  state_in     = jfc_pkg::ST_IDLE;
               end
            end else begin
               // Fetch the head entry and start the walk.
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               idx_in   = '0;
               kept_in  = '0;
               found_in = 1'b0;
               state_in = jfc_pkg::ST_WALK;
            end
         end

         jfc_pkg::ST_WALK: begin
            case (cmd_mode_ff)
               jfc_pkg::MODE_PRINT: begin
                  // Report the head and pop it.
                  if (out_free) begin
                     emit         = 1'b1;
                     emit_outcome = jfc_pkg::OUT_PRINTED;
                     emit_name    = rd_name;
                     emit_pages   = rd_pages;
                     head_in      = ring_add(head_ff, CNT_W'(1));
                     count_in     = count_ff - CNT_W'(1);
                     state_in     = jfc_pkg::ST_IDLE;
                  end
               end
               jfc_pkg::MODE_STATUS: begin
                  // One item per entry; hold the read data while the output stalls.
                  if (out_free) begin
                     emit         = 1'b1;
                     emit_outcome = jfc_pkg::OUT_STATUS;
                     emit_pos     = POS_W'(idx_ff) + POS_W'(1);
                     emit_name    = rd_name;
                     emit_pages   = rd_pages;
                     emit_last    = walk_last;
                     if (walk_last) begin
                        state_in = jfc_pkg::ST_IDLE;
                     end else begin
                        rd_en  = 1'b1;
                        idx_in = idx_next;
                     end
                  end
               end
               jfc_pkg::MODE_CANCEL: begin
                  // Compact survivors toward the head; the write slot never passes
                  // the next read slot, so read and write never hit the same entry.
                  if (jfc_pkg::names_match(rd_name, cmd_name_ff, NAME_CHARS)) begin
                     found_in = 1'b1;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = ring_add(head_ff, kept_ff);
                     mem_wdata = rd_data_ff;
                     kept_in   = kept_ff + CNT_W'(1);
                  end
                  if (walk_last) begin
                     state_in = jfc_pkg::ST_FIN;
                  end else begin
                     rd_en  = 1'b1;
                     idx_in = idx_next;
                  end
               end
               default: begin
                  state_in = jfc_pkg::ST_IDLE;
               end
            endcase
         end

         jfc_pkg::ST_FIN: begin
            // Close a cancel: shrink the queue and report.
            if (out_free) begin
               emit         = 1'b1;
               emit_outcome = found_ff ? jfc_pkg::OUT_CANCELLED : jfc_pkg::OUT_NOT_FOUND;
               count_in     = kept_ff;
               state_in     = jfc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = jfc_pkg::ST_IDLE;
         end
      endcase

      // Output register: drop on handshake, load on emit.
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_name_in    = rsp_name_ff;
      rsp_pages_in   = rsp_pages_ff;
      rsp_last_in    = rsp_last_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_outcome_in = emit_outcome;
         rsp_pos_in     = emit_pos;
         rsp_name_in    = emit_name;
         rsp_pages_in   = emit_pages;
         rsp_last_in    = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jfc_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      kept_ff        <= kept_in;
      found_ff       <= found_in;
      cmd_mode_ff    <= cmd_mode_in;
      cmd_name_ff    <= cmd_name_in;
      cmd_pages_ff   <= cmd_pages_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_name_ff    <= rsp_name_in;
      rsp_pages_ff   <= rsp_pages_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/jfc_checker.sv =====
// jfc_port_checker: port-level checks of the print job queue, bound to the top level.
// Depends on jfc_pkg and job_fifo_with_cancel_top.
`default_nettype none

module jfc_port_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input wire [2:0]                 rsp_outcome,
   input wire [jfc_pkg::POS_W-1:0]  rsp_pos,
   input wire [jfc_pkg::NAME_W-1:0] rsp_name,
   input wire [jfc_pkg::PAGE_W-1:0] rsp_pages,
   input wire                       rsp_last
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome) && $stable(rsp_pos)
         && $stable(rsp_name) && $stable(rsp_pages) && $stable(rsp_last))
      else $error("stalled result changed");

   // Only status items carry a position; every other item is the last of its command.
   a_pos_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_outcome == jfc_pkg::OUT_STATUS) == (rsp_pos != '0))
         && ((rsp_outcome == jfc_pkg::OUT_STATUS) || rsp_last))
      else $error("position or last flag inconsistent with outcome");

   // Only printed and status items carry a job.
   a_job_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != jfc_pkg::OUT_PRINTED && rsp_outcome != jfc_pkg::OUT_STATUS
         |-> rsp_name == '0 && rsp_pages == '0)
      else $error("job data on an item without a job");

   // Status positions count up by one within a listing.
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_outcome == jfc_pkg::OUT_STATUS && !rsp_last
         ##1 rsp_valid |-> rsp_outcome == jfc_pkg::OUT_STATUS
         && rsp_pos == $past(rsp_pos) + 7'd1)
      else $error("status listing broke sequence");

endmodule

bind job_fifo_with_cancel_top jfc_port_checker u_jfc_port_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_outcome (rsp_chan.outcome),
   .rsp_pos     (rsp_chan.entry_position),
   .rsp_name    (rsp_chan.result_name),
   .rsp_pages   (rsp_chan.result_pages),
   .rsp_last    (rsp_chan.last_result)
);

`default_nettype wire

// ===== dv/jfc_checker.sv =====
// jfc_checker: watches the request and response channels of the print job queue,
// keeps its own copy of the job queue and compares every response with the expected one.
// Depends on jfc_pkg and the jfc_req_if / jfc_rsp_if interfaces.

module jfc_checker #(
   parameter int QUEUE_DEPTH = jfc_pkg::QUEUE_DEPTH_DEF,
   parameter int NAME_CHARS  = jfc_pkg::NAME_CHARS_DEF
) (
   input  logic clock,
   input  logic reset,
   jfc_req_if   req_mon,
   jfc_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import jfc_pkg::*;

   typedef struct {
      outcome_type       outcome;
      logic [POS_W-1:0]  position;
      logic [NAME_W-1:0] name;
      logic [PAGE_W-1:0] pages;
      logic              last;
   } job_result_t;

   job_result_t       expected_results[$];
   job_result_t       oldest;
   logic [NAME_W-1:0] queued_names[QUEUE_DEPTH];
   logic [PAGE_W-1:0] queued_pages[QUEUE_DEPTH];
   int                queued_count;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      queued_count  = 0;
   end

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   // Keep the first NAME_CHARS bytes up to the first zero byte, clear the rest.
   function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] n);
      logic [NAME_W-1:0] r;
      r = '0;
      for (int i = 0; i < NAME_CHARS; i++) begin
         if (n[8*i +: 8] == 8'h00) begin
            break;
         end
         r[8*i +: 8] = n[8*i +: 8];
      end
      return r;
   endfunction

   function automatic logic same_name(input logic [NAME_W-1:0] a, input logic [NAME_W-1:0] b);
      logic [7:0] ca;
      logic [7:0] cb;
      for (int i = 0; i < NAME_CHARS; i++) begin
         ca = to_lower(a[8*i +: 8]);
         cb = to_lower(b[8*i +: 8]);
         if (ca != cb) begin
            return 1'b0;
         end
         if (ca == 8'h00) begin
            return 1'b1;
         end
      end
      return 1'b1;
   endfunction

   task automatic push_result(input outcome_type o, input int pos,
                              input logic [NAME_W-1:0] nm, input logic [PAGE_W-1:0] pg,
                              input logic lst);
      job_result_t r;
      r.outcome  = o;
      r.position = pos[POS_W-1:0];
      r.name     = nm;
      r.pages    = pg;
      r.last     = lst;
      expected_results.push_back(r);
   endtask

   task automatic predict_command(input mode_type m, input logic [NAME_W-1:0] nm,
                                  input logic [PAGE_W-1:0] pg);
      int   kept;
      logic hit;
      if (m == MODE_ADD) begin
         if (queued_count >= QUEUE_DEPTH) begin
            push_result(OUT_FULL, 0, '0, '0, 1'b1);
         end else begin
            queued_names[queued_count] = trim_name(nm);
            queued_pages[queued_count] = pg;
            queued_count++;
            push_result(OUT_ADDED, 0, '0, '0, 1'b1);
         end
      end else if (queued_count == 0) begin
         push_result(OUT_EMPTY, 0, '0, '0, 1'b1);
      end else if (m == MODE_CANCEL) begin
         kept = 0;
         hit  = 1'b0;
         for (int i = 0; i < queued_count; i++) begin
            if (same_name(queued_names[i], nm)) begin
               hit = 1'b1;
            end else begin
               queued_names[kept] = queued_names[i];
               queued_pages[kept] = queued_pages[i];
               kept++;
            end
         end
         queued_count = kept;
         if (hit) begin
            push_result(OUT_CANCELLED, 0, '0, '0, 1'b1);
         end else begin
            push_result(OUT_NOT_FOUND, 0, '0, '0, 1'b1);
         end
      end else if (m == MODE_PRINT) begin
         push_result(OUT_PRINTED, 0, queued_names[0], queued_pages[0], 1'b1);
         for (int i = 1; i < queued_count; i++) begin
            queued_names[i-1] = queued_names[i];
            queued_pages[i-1] = queued_pages[i];
         end
         queued_count--;
      end else begin
         for (int i = 0; i < queued_count; i++) begin
            push_result(OUT_STATUS, i + 1, queued_names[i], queued_pages[i],
                        i == queued_count - 1);
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("[%0t] MISMATCH: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         queued_count = 0;
         expected_results.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            predict_command(req_mon.mode, req_mon.job_name, req_mon.page_total);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("response with none expected, outcome %0d",
                                         rsp_mon.outcome));
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_mon.outcome !== oldest.outcome) begin
                  report_mismatch($sformatf("outcome %0d, expected %0d",
                                            rsp_mon.outcome, oldest.outcome));
               end
               if (rsp_mon.entry_position !== oldest.position) begin
                  report_mismatch($sformatf("entry_position %0d, expected %0d",
                                            rsp_mon.entry_position, oldest.position));
               end
               if (rsp_mon.result_name !== oldest.name) begin
                  report_mismatch($sformatf("result_name %h, expected %h",
                                            rsp_mon.result_name, oldest.name));
               end
               if (rsp_mon.result_pages !== oldest.pages) begin
                  report_mismatch($sformatf("result_pages %h, expected %h",
                                            rsp_mon.result_pages, oldest.pages));
               end
               if (rsp_mon.last_result !== oldest.last) begin
                  report_mismatch($sformatf("last_result %b, expected %b",
                                            rsp_mon.last_result, oldest.last));
               end
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// ===== dv/tb_job_fifo_with_cancel_top.sv =====
// tb_job_fifo_with_cancel_top: drives commands into the print job queue and gives the verdict;
// response checking lives in jfc_checker, instantiated beside the block.
// Depends on jfc_pkg, jfc_if, jfc_checker and job_fifo_with_cancel_top.

module tb_job_fifo_with_cancel_top;
   timeunit 1ns;
   timeprecision 1ps;
   import jfc_pkg::*;

   localparam int CYCLE_LIMIT    = 300000;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 30;
   localparam int NAME_POOL_SIZE = 7;

   logic clock;
   logic reset;
   int   mismatch_total;
   int   results_outstanding;
   int   cycle_count;

   // Idle odds in percent, changed per phase by the stimulus process.
   int   send_idle_pct = 9;
   int   recv_idle_pct = 72;
   // Long receiver stall: raised by the stimulus, counted down by the receiver.
   logic hold_request  = 1'b0;
   int   stall_left;

   // Small set of base names, so that cancels hit stored jobs often.
   string name_pool[NAME_POOL_SIZE] = '{"spool", "Report", "a", "INVOICE8", "q3", "Lbl-7", ""};

   jfc_req_if req_bus ();
   jfc_rsp_if rsp_bus ();

   job_fifo_with_cancel_top #(
      .QUEUE_DEPTH (QUEUE_DEPTH_DEF),
      .NAME_CHARS  (NAME_CHARS_DEF)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   jfc_checker #(
      .QUEUE_DEPTH (QUEUE_DEPTH_DEF),
      .NAME_CHARS  (NAME_CHARS_DEF)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (mismatch_total),
      .pending_count (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if the queue hangs or responses never drain.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** job_fifo_with_cancel_top: FAILED **");
      $finish;
   end

   // Receiver: drop ready at random, or for a long counted stretch on request.
   initial begin
      rsp_bus.ready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Pack a string into a name, first character in the low byte.
   function automatic logic [NAME_W-1:0] pack_name(input string s);
      logic [NAME_W-1:0] r;
      r = '0;
      for (int i = 0; i < s.len() && i < NAME_BYTES; i++) begin
         r[8*i +: 8] = s[i];
      end
      return r;
   endfunction

   // Pool name with random letter case, sometimes with junk after the terminator;
   // now and then a fully random 64-bit name.
   function automatic logic [NAME_W-1:0] rand_job_name();
      logic [NAME_W-1:0] nm;
      logic [7:0]        c;
      int                len;
      if ($urandom_range(9) == 0) begin
         return {$urandom, $urandom};
      end
      nm  = pack_name(name_pool[$urandom_range(NAME_POOL_SIZE - 1)]);
      len = 0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         c = nm[8*i +: 8];
         if (c != 8'h00) begin
            len = i + 1;
         end
         if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
             $urandom_range(1) == 1) begin
            nm[8*i +: 8] = c ^ 8'h20;
         end
      end
      if (len < NAME_BYTES - 1 && $urandom_range(3) == 0) begin
         for (int i = len + 1; i < NAME_BYTES; i++) begin
            nm[8*i +: 8] = 8'($urandom_range(255));
         end
      end
      return nm;
   endfunction

   // Offer one item, maybe after an idle gap, and hold it until taken.
   task automatic send_item(input mode_type m, input logic [NAME_W-1:0] nm,
                            input logic [PAGE_W-1:0] pg);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= m;
      req_bus.job_name   <= nm;
      req_bus.page_total <= pg;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   // Stop offering and hold until every expected response has come back.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (results_outstanding == 0);
      @(posedge clock);
   endtask

   // Adds most often, so the queue fills and cancels and listings have work to do.
   task automatic send_random_items(input int count);
      mode_type          m;
      logic [PAGE_W-1:0] pg;
      int                pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            m = MODE_ADD;
         end else if (pick < 65) begin
            m = MODE_CANCEL;
         end else if (pick < 80) begin
            m = MODE_PRINT;
         end else begin
            m = MODE_STATUS;
         end
         pick = $urandom_range(19);
         if (pick == 0) begin
            pg = '0;
         end else if (pick == 1) begin
            pg = '1;
         end else begin
            pg = PAGE_W'($urandom_range(1, 65535));
         end
         send_item(m, rand_job_name(), pg);
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.mode       <= MODE_ADD;
      req_bus.job_name   <= '0;
      req_bus.page_total <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sender idles rarely, receiver often.
      send_idle_pct = 9;
      recv_idle_pct = 72;

      // Directed: every command on an empty queue.
      send_item(MODE_PRINT, {$urandom, $urandom}, PAGE_W'($urandom));
      send_item(MODE_CANCEL, pack_name("JobA"), PAGE_W'($urandom));
      send_item(MODE_STATUS, {$urandom, $urandom}, PAGE_W'($urandom));
      // Field extremes, zero name and zero pages, junk after the terminator,
      // the characters just outside A-Z, and a name of all eight characters.
      send_item(MODE_ADD, pack_name("JobA"), 16'd1);
      send_item(MODE_ADD, '1, '1);
      send_item(MODE_ADD, '0, '0);
      send_item(MODE_ADD, 64'h5A5A_5A5A_5A00_6261, 16'h1234);
      send_item(MODE_ADD, pack_name("JOBA"), 16'h8000);
      send_item(MODE_ADD, pack_name("@["), 16'd7);
      send_item(MODE_ADD, pack_name("abcdefgh"), 16'd2);
      send_item(MODE_STATUS, '0, '0);
      // Cancel both spellings at once, miss on the near-letters, then hit the
      // empty name, the junk-tailed name and the full-length name.
      send_item(MODE_CANCEL, pack_name("joba"), '0);
      send_item(MODE_CANCEL, pack_name("`{"), '0);
      send_item(MODE_CANCEL, '0, '1);
      send_item(MODE_CANCEL, 64'hC3C3_C3C3_C300_4241, '0);
      send_item(MODE_CANCEL, pack_name("ABCDEFGH"), '0);
      send_item(MODE_PRINT, '0, '0);
      send_item(MODE_CANCEL, pack_name("@["), '0);
      send_item(MODE_STATUS, '1, '1);
      send_item(MODE_PRINT, '1, '1);
      wait_for_results();

      send_random_items(20);

      // Pressure: receiver stalls for a long stretch, so adds back up into the input;
      // with more adds than the queue holds, it fills and reports full.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      repeat (QUEUE_DEPTH_DEF + 8) begin
         send_item(MODE_ADD, rand_job_name(), PAGE_W'($urandom_range(1, 65535)));
      end
      send_item(MODE_STATUS, '0, '0);
      wait_for_results();

      // Phase two: roles swapped.
      send_idle_pct = 72;
      recv_idle_pct = 9;
      send_random_items(20);

      // Phase three: no idling on either side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_items(15);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && results_outstanding == 0) begin
         $display("** job_fifo_with_cancel_top: PASSED **");
      end else begin
         $display("** job_fifo_with_cancel_top: FAILED **");
      end
      $finish;
   end

endmodule
